// ===== design/slope_pulse_flow_meter_macros.svh =====
// ----------------------------------------------------------------------------
// Slope pulse flow meter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef SLOPE_PULSE_FLOW_METER_MACROS_SVH
`define SLOPE_PULSE_FLOW_METER_MACROS_SVH

// Property that holds at every clock edge out of reset
`define SPFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent that, once seen, requires the consequent at the following edge
`define SPFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Slope pulse flow meter package
// Fixed widths, constants and register indexes shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spfm_pkg;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned PPL_W        = 16;
  localparam int unsigned DEN_W        = TIME_W + PPL_W;
  localparam int unsigned MUL_W        = 32;
  localparam int unsigned FLOW_W       = 24;
  localparam int unsigned LIM_W        = 19;
  localparam int unsigned ALPHA_W      = 9;
  localparam int unsigned SECS_W       = 23;
  localparam int unsigned CFG_W        = 24;
  localparam int unsigned CFG_IDX_W    = 3;

  // Flow numerator: 60e6 us per minute, before fraction scaling
  localparam int unsigned FLOW_SCALE   = 60000000;
  localparam int unsigned FLOW_SCALE_W = 26;
  localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

  // Smoothing weight, Q1.8
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;
  localparam int unsigned        ALPHA_FRAC = 8;
  localparam int unsigned        ROUND_HALF = 128;

  // x / 1000 as (x * RECIP_1000) >> RECIP_SHIFT, exact for 32 bit x
  localparam logic [MUL_W-1:0] RECIP_1000  = 32'd274877907;
  localparam int unsigned      RECIP_SHIFT = 38;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_INTERVAL   = 3'd0,
    CFG_SMOOTH_ALPHA    = 3'd1,
    CFG_RISE_LIMIT      = 3'd2,
    CFG_FALL_LIMIT      = 3'd3,
    CFG_PULSES_PER_L    = 3'd4,
    CFG_REPORT_INTERVAL = 3'd5,
    CFG_IDLE_TIMEOUT    = 3'd6,
    CFG_MAX_FLOW        = 3'd7
  } cfg_idx_e;

  // Register reset values
  localparam logic [15:0]        RST_READ_INTERVAL   = 16'd10;
  localparam logic [ALPHA_W-1:0] RST_SMOOTH_ALPHA    = 9'd26;
  localparam logic [LIM_W-1:0]   RST_RISE_LIMIT      = 19'sd256;
  localparam logic [LIM_W-1:0]   RST_FALL_LIMIT      = -19'sd256;
  localparam logic [PPL_W-1:0]   RST_PULSES_PER_L    = 16'd1000;
  localparam logic [15:0]        RST_REPORT_INTERVAL = 16'd1000;
  localparam logic [23:0]        RST_IDLE_TIMEOUT    = 24'd30000;
  localparam logic [FLOW_W-1:0]  RST_MAX_FLOW        = 24'd25600;

endpackage

// ===== design/slope_pulse_flow_meter.sv =====
// ----------------------------------------------------------------------------
// Slope pulse flow meter
// Smoothed level, slope edge detection, pulse counting and flow reporting.
// ----------------------------------------------------------------------------
// Sequence: an item that is not read passes ST_GATE, ST_REPORT, ST_SECS and
// ST_OUT; a reading adds ST_EMA_B and ST_EMA_SUM, and a pulse that recomputes
// the flow adds ST_DEN and, for a nonzero divisor, ST_DIV. One item at a time;
// the next beat can be taken the cycle after the result is loaded. The flow quotient
// comes from the bit serial divider (NUM_W = 26 + FRACTION_BITS steps).
// Async reset (active low) loads register defaults, clears all but the captures.
`timescale 1ns / 1ps

module slope_pulse_flow_meter #(
  parameter int unsigned SAMPLE_BITS   = 10,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration writes
  input  logic                                 cfg_we_i,
  input  logic [spfm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [spfm_pkg::CFG_W-1:0]           cfg_data_i,
  // Input beats
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [spfm_pkg::TIME_W-1:0]          now_ms_i,
  input  logic [spfm_pkg::TIME_W-1:0]          now_us_i,
  input  logic [spfm_pkg::SAMPLE_W-1:0]        sample_i,
  // Result beats
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 pulse_o,
  output logic                                 trend_o,
  output logic [spfm_pkg::FLOW_W-1:0]          flow_q8_o,
  output logic                                 flow_in_range_o,
  output logic [spfm_pkg::TIME_W-1:0]          pulse_count_o,
  output logic [spfm_pkg::TIME_W-1:0]          run_pulses_o,
  output logic [spfm_pkg::SECS_W-1:0]          run_seconds_o,
  output logic                                 report_o,
  output logic                                 flow_stopped_o
);

  localparam int unsigned LVL_W  = SAMPLE_BITS + FRACTION_BITS;
  localparam int unsigned ACC_W  = LVL_W + spfm_pkg::ALPHA_FRAC + 1;
  localparam int unsigned NUM_W  = spfm_pkg::FLOW_SCALE_W + FRACTION_BITS;
  localparam int unsigned DEN_W  = spfm_pkg::DEN_W;
  localparam int unsigned MUL_W  = spfm_pkg::MUL_W;
  localparam int unsigned TW     = spfm_pkg::TIME_W;
  localparam int unsigned LIM_W  = spfm_pkg::LIM_W;
  localparam int unsigned SMP_XW = spfm_pkg::SAMPLE_W + 1;

  localparam logic [NUM_W-1:0]  FLOW_NUM   = NUM_W'(spfm_pkg::FLOW_SCALE) << FRACTION_BITS;
  localparam logic [SMP_XW-1:0] SAMPLE_LIM = SMP_XW'(1) << SAMPLE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATE,
    ST_EMA_B,
    ST_EMA_SUM,
    ST_DEN,
    ST_DIV,
    ST_REPORT,
    ST_SECS,
    ST_OUT
  } state_e;

  // Configuration registers
  logic [15:0]                   read_int_q;
  logic [spfm_pkg::ALPHA_W-1:0]  alpha_q;
  logic [LIM_W-1:0]              rise_q, fall_q;
  logic [spfm_pkg::PPL_W-1:0]    ppl_q;
  logic [15:0]                   rep_int_q;
  logic [23:0]                   idle_q;
  logic [spfm_pkg::FLOW_W-1:0]   max_flow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_int_q <= spfm_pkg::RST_READ_INTERVAL;
      alpha_q    <= spfm_pkg::RST_SMOOTH_ALPHA;
      rise_q     <= spfm_pkg::RST_RISE_LIMIT;
      fall_q     <= spfm_pkg::RST_FALL_LIMIT;
      ppl_q      <= spfm_pkg::RST_PULSES_PER_L;
      rep_int_q  <= spfm_pkg::RST_REPORT_INTERVAL;
      idle_q     <= spfm_pkg::RST_IDLE_TIMEOUT;
      max_flow_q <= spfm_pkg::RST_MAX_FLOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spfm_pkg::CFG_READ_INTERVAL:   read_int_q <= cfg_data_i[15:0];
        spfm_pkg::CFG_SMOOTH_ALPHA:    alpha_q    <= cfg_data_i[spfm_pkg::ALPHA_W-1:0];
        spfm_pkg::CFG_RISE_LIMIT:      rise_q     <= cfg_data_i[LIM_W-1:0];
        spfm_pkg::CFG_FALL_LIMIT:      fall_q     <= cfg_data_i[LIM_W-1:0];
        spfm_pkg::CFG_PULSES_PER_L:    ppl_q      <= cfg_data_i[spfm_pkg::PPL_W-1:0];
        spfm_pkg::CFG_REPORT_INTERVAL: rep_int_q  <= cfg_data_i[15:0];
        spfm_pkg::CFG_IDLE_TIMEOUT:    idle_q     <= cfg_data_i[23:0];
        spfm_pkg::CFG_MAX_FLOW:        max_flow_q <= cfg_data_i[spfm_pkg::FLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and meter state
  state_e                       state_q;
  logic [LVL_W-1:0]             level_q, prev_q;
  logic                         rising_q;
  logic [TW-1:0]                last_read_q, last_edge_q, last_pulse_q, run_start_q;
  logic [TW-1:0]                total_q, run_start_pls_q, last_report_q;
  logic [spfm_pkg::FLOW_W-1:0]  flow_q;
  logic                         pulse_q, report_q, stop_q;

  // Captured item and first EMA product
  logic [TW-1:0]                now_ms_q, now_us_q;
  logic [spfm_pkg::SAMPLE_W-1:0] sample_q;
  logic [ACC_W-1:0]             p1_q;

  // Result register
  logic                         out_valid_q;
  logic                         o_pulse_q, o_trend_q, o_in_range_q, o_report_q, o_stop_q;
  logic [spfm_pkg::FLOW_W-1:0]  o_flow_q;
  logic [TW-1:0]                o_count_q, o_run_pls_q;
  logic [spfm_pkg::SECS_W-1:0]  o_secs_q;

  // Multiplier shared across the steps, and the flow divider
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   quot;

  spfm_mul #(
    .W (MUL_W)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  spfm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (FLOW_NUM),
    .den_i   (prod[DEN_W-1:0]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Reading gate
  logic read_ok;
  assign read_ok = ((now_ms_q - last_read_q) > TW'(read_int_q)) && (now_ms_q != '0) &&
                   (sample_q != '0) && ({1'b0, sample_q} < SAMPLE_LIM);

  // Smoothing weights
  logic [spfm_pkg::ALPHA_W-1:0] alpha_sat, alpha_inv;
  assign alpha_sat = (alpha_q > spfm_pkg::ALPHA_ONE) ? spfm_pkg::ALPHA_ONE : alpha_q;
  assign alpha_inv = spfm_pkg::ALPHA_ONE - alpha_sat;

  // New level from both products, rounded half up
  logic [ACC_W-1:0] acc;
  logic [LVL_W-1:0] lvl_new;
  assign acc     = p1_q + prod[ACC_W-1:0] + ACC_W'(spfm_pkg::ROUND_HALF);
  assign lvl_new = acc[spfm_pkg::ALPHA_FRAC +: LVL_W];

  // Slope against the limits, sign extended to one width
  logic signed [LVL_W:0] slope;
  logic signed [TW-1:0]  slope_x, rise_x, fall_x;
  assign slope   = $signed({1'b0, lvl_new}) - $signed({1'b0, prev_q});
  assign slope_x = {{(TW-LVL_W-1){slope[LVL_W]}}, slope};
  assign rise_x  = {{(TW-LIM_W){rise_q[LIM_W-1]}}, rise_q};
  assign fall_x  = {{(TW-LIM_W){fall_q[LIM_W-1]}}, fall_q};

  // Edge decisions; a rise and a fall can both hit in the same reading, sharing its timestamp
  logic          rise_hit, fall_hit, rising_mid, edge_any;
  logic [1:0]    edge_cnt;
  logic [TW-1:0] interval;
  assign rise_hit   = (slope_x > rise_x) && !rising_q;
  assign rising_mid = rising_q | rise_hit;
  assign fall_hit   = (slope_x < fall_x) && rising_mid;
  assign edge_any   = rise_hit | fall_hit;
  assign edge_cnt   = {1'b0, rise_hit} + {1'b0, fall_hit};
  assign interval   = now_us_q - last_edge_q;

  // Run length for the seconds figure
  logic [TW-1:0] run_ms;
  assign run_ms = last_pulse_q - run_start_q;

  // Multiplier operand select
  always_comb begin
    case (state_q)
      ST_GATE: begin
        mul_a = MUL_W'(alpha_inv);
        mul_b = MUL_W'(level_q);
      end
      ST_EMA_B: begin
        mul_a = MUL_W'(alpha_sat);
        mul_b = MUL_W'({sample_q[SAMPLE_BITS-1:0], {FRACTION_BITS{1'b0}}});
      end
      ST_EMA_SUM: begin
        mul_a = interval;
        mul_b = MUL_W'(ppl_q);
      end
      default: begin
        mul_a = run_ms;
        mul_b = spfm_pkg::RECIP_1000;
      end
    endcase
  end

  assign div_start = (state_q == ST_DEN) && (prod[DEN_W-1:0] != '0);

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // Captured item and first product, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_ms_q <= now_ms_i;
      now_us_q <= now_us_i;
      sample_q <= sample_i;
    end
    if (state_q == ST_EMA_B) begin
      p1_q <= prod[ACC_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      level_q         <= '0;
      prev_q          <= '0;
      rising_q        <= 1'b0;
      last_read_q     <= '0;
      last_edge_q     <= '0;
      last_pulse_q    <= '0;
      run_start_q     <= '0;
      total_q         <= '0;
      run_start_pls_q <= '0;
      last_report_q   <= '0;
      flow_q          <= '0;
      pulse_q         <= 1'b0;
      report_q        <= 1'b0;
      stop_q          <= 1'b0;
      out_valid_q     <= 1'b0;
      o_pulse_q       <= 1'b0;
      o_trend_q       <= 1'b0;
      o_in_range_q    <= 1'b0;
      o_report_q      <= 1'b0;
      o_stop_q        <= 1'b0;
      o_flow_q        <= '0;
      o_count_q       <= '0;
      o_run_pls_q     <= '0;
      o_secs_q        <= '0;
    end else begin
      // Result beat leaves; a new load in ST_OUT sets valid instead
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            pulse_q  <= 1'b0;
            report_q <= 1'b0;
            stop_q   <= 1'b0;
            state_q  <= ST_GATE;
          end
        end
        ST_GATE: begin
          state_q <= read_ok ? ST_EMA_B : ST_REPORT;
        end
        ST_EMA_B: begin
          state_q <= ST_EMA_SUM;
        end
        // Level update, edge detection and pulse bookkeeping
        ST_EMA_SUM: begin
          last_read_q <= now_ms_q;
          level_q     <= lvl_new;
          prev_q      <= lvl_new;
          rising_q    <= rising_mid & ~fall_hit;
          state_q     <= ST_REPORT;
          if (edge_any) begin
            pulse_q     <= 1'b1;
            last_edge_q <= now_us_q;
            total_q     <= total_q + TW'(edge_cnt);
            if (interval != '0) begin
              if (flow_q == '0) begin
                run_start_pls_q <= total_q;
                run_start_q     <= now_ms_q;
              end
              last_pulse_q <= now_ms_q;
              state_q      <= ST_DEN;
            end
          end
        end
        // Divisor ready: zero saturates, otherwise divide
        ST_DEN: begin
          if (prod[DEN_W-1:0] == '0) begin
            flow_q  <= spfm_pkg::FLOW_MAX;
            state_q <= ST_REPORT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            flow_q  <= (quot > NUM_W'(spfm_pkg::FLOW_MAX)) ? spfm_pkg::FLOW_MAX
                                                           : quot[spfm_pkg::FLOW_W-1:0];
            state_q <= ST_REPORT;
          end
        end
        // Periodic report and idle timeout
        ST_REPORT: begin
          if ((now_ms_q - last_report_q) > TW'(rep_int_q)) begin
            last_report_q <= now_ms_q;
            report_q      <= 1'b1;
            if ((now_ms_q - last_pulse_q) > TW'(idle_q)) begin
              stop_q          <= 1'b1;
              flow_q          <= '0;
              run_start_pls_q <= total_q;
              run_start_q     <= last_pulse_q;
            end
          end
          state_q <= ST_SECS;
        end
        ST_SECS: begin
          state_q <= ST_OUT;
        end
        // Load the result register once it is free
        ST_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            o_pulse_q    <= pulse_q;
            o_trend_q    <= rising_q;
            o_flow_q     <= flow_q;
            o_in_range_q <= flow_q < max_flow_q;
            o_count_q    <= total_q;
            o_run_pls_q  <= total_q - run_start_pls_q;
            o_secs_q     <= prod[spfm_pkg::RECIP_SHIFT +: spfm_pkg::SECS_W];
            o_report_q   <= report_q;
            o_stop_q     <= stop_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign pulse_o         = o_pulse_q;
  assign trend_o         = o_trend_q;
  assign flow_q8_o       = o_flow_q;
  assign flow_in_range_o = o_in_range_q;
  assign pulse_count_o   = o_count_q;
  assign run_pulses_o    = o_run_pls_q;
  assign run_seconds_o   = o_secs_q;
  assign report_o        = o_report_q;
  assign flow_stopped_o  = o_stop_q;

endmodule

// ===== design/spfm_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned W x W multiply with a registered product, reused across the steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spfm_mul #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] prod_o
);

  logic [2*W-1:0] prod_q;

  // Product lands in the cycle after the operands
  always_ff @(posedge clk_i) begin
    prod_q <= (2*W)'(a_i) * (2*W)'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== design/spfm_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle, NUM_W quotient bits per divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spfm_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q, den_q;

  logic [DEN_W:0]   shifted, diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  // Control: step count and completion strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out, quotient bits shift in behind it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== design/slope_pulse_flow_meter_chk.sv =====
// ----------------------------------------------------------------------------
// Slope pulse flow meter checker
// Port level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slope_pulse_flow_meter_macros.svh"

module slope_pulse_flow_meter_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 pulse_o,
  input logic                                 trend_o,
  input logic [spfm_pkg::FLOW_W-1:0]          flow_q8_o,
  input logic                                 flow_in_range_o,
  input logic [spfm_pkg::TIME_W-1:0]          pulse_count_o,
  input logic [spfm_pkg::TIME_W-1:0]          run_pulses_o,
  input logic [spfm_pkg::SECS_W-1:0]          run_seconds_o,
  input logic                                 report_o,
  input logic                                 flow_stopped_o
);

  localparam int unsigned HELD_W = spfm_pkg::FLOW_W + 2 * spfm_pkg::TIME_W +
                                   spfm_pkg::SECS_W + 5;

  // Handshake terms and the whole result payload
  logic              out_stall, in_beat, stop_beat, run_clear;
  logic [HELD_W-1:0] held;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_beat   = in_valid_i && in_ready_o;
  assign stop_beat = out_valid_o && flow_stopped_o;
  assign run_clear = report_o && (flow_q8_o == '0) && (run_pulses_o == '0) &&
                     (run_seconds_o == '0);
  assign held      = {pulse_o, trend_o, flow_q8_o, flow_in_range_o, pulse_count_o,
                      run_pulses_o, run_seconds_o, report_o, flow_stopped_o};

  // A stalled result beat holds its payload
  `SPFM_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(held), "stalled result changed")

  // One item in flight: no input beat in the cycle after one is taken
  `SPFM_ASSERT_NEXT(a_one_item, in_beat, !in_ready_o, "input taken on consecutive cycles")

  // A stopped run only comes with a report and leaves an empty run
  `SPFM_ASSERT(a_stop_report, !stop_beat || run_clear, "stop without report or with run data")

endmodule

bind slope_pulse_flow_meter slope_pulse_flow_meter_chk u_chk (.*);
